FILE: src/ffba_pkg.sv
// Shared constants for the first-fit block allocator.
// Used by first_fit_block_allocator; no dependencies.
package ffba_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 65536;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned GRANULE_BYTES    = 16;
  localparam int unsigned GRANULE_SHIFT    = 4;
  localparam int unsigned SIZE_W           = 13;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MEM    = 2'd1;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

endpackage

FILE: src/ffba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/first_fit_block_allocator.sv
// First-fit allocator over a fixed arena; block headers live in one RAM, ffba_ram.
// Depends on ffba_pkg and ffba_ram.
//
// After reset the block clears its header RAM, one entry per cycle over all ARENA_BYTES/16
// entries, and holds in_stall high meanwhile. An allocate walks the chain from the first
// header, one header read per cycle, then marks the fitting block used; when the remainder
// is split off it writes the new header, and when that header has a follower it fixes the
// follower's back link. A free checks its block and merges it with any free neighbor before
// and after it, fixing back links as needed; a zero-size request or a free rejected on its
// address ends without a header read, and a free of a block that is not in use ends after
// one. The header RAM has one write port and a registered read. in_stall stays high until
// an item is handed over, and a result waits in an output register while out_stall is high.
module first_fit_block_allocator #(
  parameter int unsigned ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [15:0] in_request_bytes,
  input  logic [31:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_granted_address,
  output logic [1:0]  out_status
);

  localparam int unsigned NGRAN = ARENA_BYTES / ffba_pkg::GRANULE_BYTES;
  localparam int unsigned HGRAN =
    (HEADER_BYTES + ffba_pkg::GRANULE_BYTES - 1) / ffba_pkg::GRANULE_BYTES;
  localparam int unsigned GW = $clog2(NGRAN);
  localparam int unsigned AW = ((GW > ffba_pkg::SIZE_W) ? GW : ffba_pkg::SIZE_W) + 3;

  typedef struct packed {
    logic          valid;
    logic          used;
    logic          has_next;
    logic [GW-1:0] next;
    logic          has_prev;
    logic [GW-1:0] prev;
  } hdr_t;

  localparam int unsigned HW = $bits(hdr_t);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_CK  = 4'd2;
  localparam logic [3:0] S_A_WNB = 4'd3;
  localparam logic [3:0] S_F_CB  = 4'd4;
  localparam logic [3:0] S_F_CP  = 4'd5;
  localparam logic [3:0] S_F_NX  = 4'd6;
  localparam logic [3:0] S_F_CN  = 4'd7;
  localparam logic [3:0] S_F_WB  = 4'd8;
  localparam logic [3:0] S_LK_RD = 4'd9;
  localparam logic [3:0] S_LK_WR = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]  state_r, state_nxt, lk_ret_r, lk_ret_nxt;
  logic [GW-1:0] blk_r, blk_nxt, ci_r, ci_nxt, nb_r, nb_nxt;
  logic [GW-1:0] lk_idx_r, lk_idx_nxt, lk_val_r, lk_val_nxt, clr_r, clr_nxt;
  logic [ffba_pkg::SIZE_W-1:0] sz_r, sz_nxt;
  hdr_t        cur_r, cur_nxt;
  logic [31:0] res_addr_r, res_addr_nxt, base_r;
  logic [1:0]  res_st_r, res_st_nxt;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [1:0]  out_st_r;

  logic          ram_we;
  logic [GW-1:0] ram_waddr, ram_raddr;
  hdr_t          ram_wdata, rd;
  logic [HW-1:0] ram_rdata;

  ffba_ram #(.WIDTH(HW), .DEPTH(NGRAN)) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = hdr_t'(ram_rdata);

  logic        in_xfer, out_free;
  logic [16:0] req_round;
  logic [31:0] off;
  logic [28:0] g_rel;
  logic [AW-1:0] blk_end, blk_dat, blk_size, nb_calc, nb_gap;
  logic        fits, split;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign req_round = {1'b0, in_request_bytes} + 17'(ffba_pkg::GRANULE_BYTES - 1);
  assign off       = in_block_address - base_r;
  assign g_rel     = {1'b0, off[31:ffba_pkg::GRANULE_SHIFT]} - 29'(HGRAN);

  assign blk_end  = rd.has_next ? AW'(rd.next) : AW'(NGRAN);
  assign blk_dat  = AW'(blk_r) + AW'(HGRAN);
  assign blk_size = (blk_end > blk_dat) ? blk_end - blk_dat : '0;
  assign fits     = !rd.used && (blk_size >= AW'(sz_r));
  assign nb_calc  = blk_dat + AW'(sz_r);
  assign nb_gap   = AW'(rd.next) - nb_calc;
  assign split    = !rd.has_next || (nb_gap > AW'(HGRAN));

  always_comb begin
    state_nxt    = state_r;
    lk_ret_nxt   = lk_ret_r;
    blk_nxt      = blk_r;
    ci_nxt       = ci_r;
    nb_nxt       = nb_r;
    lk_idx_nxt   = lk_idx_r;
    lk_val_nxt   = lk_val_r;
    clr_nxt      = clr_r;
    sz_nxt       = sz_r;
    cur_nxt      = cur_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata.valid = (clr_r == '0);
        clr_nxt   = clr_r + GW'(1);
        if (clr_r == GW'(NGRAN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_addr_nxt = '0;
          if (in_command == ffba_pkg::CMD_ALLOC) begin
            sz_nxt  = req_round[16:ffba_pkg::GRANULE_SHIFT];
            blk_nxt = '0;
            if (in_request_bytes == '0) begin
              res_st_nxt = ffba_pkg::ST_ZERO_SIZE;
              state_nxt  = S_FIN;
            end else begin
              ram_raddr = '0;
              state_nxt = S_A_CK;
            end
          end else begin
            res_st_nxt = ffba_pkg::ST_BAD_FREE;
            if (off[ffba_pkg::GRANULE_SHIFT-1:0] != '0 || g_rel[28]
                || g_rel >= 29'(NGRAN)) begin
              state_nxt = S_FIN;
            end else begin
              ci_nxt    = g_rel[GW-1:0];
              ram_raddr = g_rel[GW-1:0];
              state_nxt = S_F_CB;
            end
          end
        end
      end
      S_A_CK: begin
        if (rd.has_next && !fits) begin
          blk_nxt   = rd.next;
          ram_raddr = rd.next;
        end else if (rd.used || (nb_calc + AW'(HGRAN)) > AW'(NGRAN)) begin
          res_st_nxt = ffba_pkg::ST_NO_MEM;
          state_nxt  = S_FIN;
        end else begin
          res_st_nxt   = ffba_pkg::ST_OK;
          res_addr_nxt = base_r + {(32 - GW - ffba_pkg::GRANULE_SHIFT)'(0),
                                   blk_dat[GW-1:0], ffba_pkg::GRANULE_SHIFT'(0)};
          ram_we    = 1'b1;
          ram_waddr = blk_r;
          ram_wdata = rd;
          ram_wdata.used = 1'b1;
          cur_nxt   = rd;
          nb_nxt    = nb_calc[GW-1:0];
          if (split) begin
            ram_wdata.has_next = 1'b1;
            ram_wdata.next     = nb_calc[GW-1:0];
            state_nxt = S_A_WNB;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_A_WNB: begin
        ram_we    = 1'b1;
        ram_waddr = nb_r;
        ram_wdata.valid    = 1'b1;
        ram_wdata.has_next = cur_r.has_next;
        ram_wdata.next     = cur_r.next;
        ram_wdata.has_prev = 1'b1;
        ram_wdata.prev     = blk_r;
        if (cur_r.has_next) begin
          lk_idx_nxt = cur_r.next;
          lk_val_nxt = nb_r;
          lk_ret_nxt = S_FIN;
          state_nxt  = S_LK_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_F_CB: begin
        if (!rd.valid || !rd.used) begin
          state_nxt = S_FIN;
        end else begin
          cur_nxt = rd;
          if (rd.has_prev) begin
            ram_raddr = rd.prev;
            state_nxt = S_F_CP;
          end else begin
            state_nxt = S_F_NX;
          end
        end
      end
      S_F_CP: begin
        state_nxt = S_F_NX;
        if (!rd.used) begin
          // Merge into the free block before: it takes over this block's forward link.
          ram_we    = 1'b1;
          ram_waddr = ci_r;
          cur_nxt   = rd;
          cur_nxt.has_next = cur_r.has_next;
          cur_nxt.next     = cur_r.next;
          ci_nxt    = cur_r.prev;
          if (cur_r.has_next) begin
            lk_idx_nxt = cur_r.next;
            lk_val_nxt = cur_r.prev;
            lk_ret_nxt = S_F_NX;
            state_nxt  = S_LK_RD;
          end
        end
      end
      S_F_NX: begin
        if (cur_r.has_next) begin
          ram_raddr = cur_r.next;
          state_nxt = S_F_CN;
        end else begin
          state_nxt = S_F_WB;
        end
      end
      S_F_CN: begin
        state_nxt = S_F_WB;
        if (!rd.used) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r.next;
          cur_nxt.has_next = rd.has_next;
          cur_nxt.next     = rd.next;
          if (rd.has_next) begin
            lk_idx_nxt = rd.next;
            lk_val_nxt = ci_r;
            lk_ret_nxt = S_F_WB;
            state_nxt  = S_LK_RD;
          end
        end
      end
      S_F_WB: begin
        ram_we    = 1'b1;
        ram_waddr = ci_r;
        ram_wdata = cur_r;
        ram_wdata.used = 1'b0;
        res_st_nxt = ffba_pkg::ST_OK;
        state_nxt  = S_FIN;
      end
      S_LK_RD: begin
        ram_raddr = lk_idx_r;
        state_nxt = S_LK_WR;
      end
      S_LK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lk_idx_r;
        ram_wdata = rd;
        ram_wdata.has_prev = 1'b1;
        ram_wdata.prev     = lk_val_r;
        state_nxt = lk_ret_r;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_ret_r   <= lk_ret_nxt;
    blk_r      <= blk_nxt;
    ci_r       <= ci_nxt;
    nb_r       <= nb_nxt;
    lk_idx_r   <= lk_idx_nxt;
    lk_val_r   <= lk_val_nxt;
    sz_r       <= sz_nxt;
    cur_r      <= cur_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    if (state_r == S_FIN && out_free) begin
      out_addr_r <= res_addr_r;
      out_st_r   <= res_st_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_st_r;

  // Error results never carry an address.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffba_pkg::ST_OK |-> out_granted_address == '0)
    else $error("error result with nonzero address");

  // A new result appears only when a finished operation is handed over.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside hand-over");

  // Reset starts the clearing pass, which blocks input transfers.
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open right after reset");

  // A header write outside clearing never hits the read address when S_LK_WR follows.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && state_r != S_CLR |-> !(state_nxt == S_LK_WR && ram_raddr == ram_waddr))
    else $error("header RAM read and write collide");

endmodule
